FILE: rtl/ppb_pkg.sv
// Package for the pixel palette builder: shared types and constants.
// Used by ppb_palette_ram, ppb_search and pixel_palette_builder_core; no dependencies.
`default_nettype none

package ppb_pkg;

  // Offset added to a palette slot to form the palette index
  localparam logic [7:0] INDEX_OFFSET = 8'd32;

  // Packed color {red, green, blue}
  localparam int unsigned COLOR_W = 24;
  typedef logic [COLOR_W-1:0] color_t;

  // One result item as produced by the search engine
  typedef struct packed {
    logic [7:0] pal_index;
    logic       new_color;
    logic [7:0] colors_in_use;
    logic       color_dropped;
  } ppb_result_t;

endpackage : ppb_pkg

`default_nettype wire

FILE: rtl/ppb_palette_ram.sv
// Palette store: single-port-write, single-port-read synchronous memory.
// Read data is registered. Depends on ppb_pkg.
`default_nettype none

module ppb_palette_ram
  import ppb_pkg::*;
#(
  parameter int unsigned DEPTH = 224,
  parameter int unsigned AW    = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output color_t             rd_data_o,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire color_t        wr_data_i
);

  color_t mem [DEPTH];
  color_t rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule : ppb_palette_ram

`default_nettype wire

FILE: rtl/ppb_search.sv
// Search engine: sweeps the filled palette, one read per cycle, up to the first match,
// then resolves hit, append or drop. Holds count and last index. Depends on ppb_pkg.
`default_nettype none

module ppb_search
  import ppb_pkg::*;
#(
  parameter int unsigned DEPTH = 224,
  parameter int unsigned AW    = 8,
  parameter int unsigned CW    = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // pixel item
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire color_t        color_i,
  input  wire logic          first_of_image_i,
  // palette memory
  output logic               rd_en_o,
  output logic [AW-1:0]      rd_addr_o,
  input  wire color_t        rd_data_i,
  output logic               wr_en_o,
  output logic [AW-1:0]      wr_addr_o,
  output color_t             wr_data_o,
  // result item
  output logic               res_valid_o,
  input  wire logic          res_take_i,
  output ppb_result_t        res_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESOLVE
  } state_e;

  state_e        state_q, state_d;
  color_t        color_q, color_d;
  logic [CW-1:0] count_q, count_d;
  logic [7:0]    last_q, last_d;
  logic [CW-1:0] scan_q, scan_d;
  logic          cmp_vld_q, cmp_vld_d;
  logic [AW-1:0] cmp_idx_q, cmp_idx_d;
  logic          hit_q, hit_d;
  logic [AW-1:0] hit_idx_q, hit_idx_d;

  logic          room;

  assign room       = (count_q != CW'(DEPTH));
  assign in_stall_o = (state_q != S_IDLE);
  assign wr_addr_o  = count_q[AW-1:0];
  assign wr_data_o  = color_q;
  assign rd_addr_o  = scan_q[AW-1:0];

  // Next state, memory control and result
  always_comb begin
    state_d     = state_q;
    color_d     = color_q;
    count_d     = count_q;
    last_d      = last_q;
    scan_d      = scan_q;
    cmp_vld_d   = cmp_vld_q;
    cmp_idx_d   = cmp_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    rd_en_o     = 1'b0;
    wr_en_o     = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          color_d   = color_i;
          scan_d    = '0;
          cmp_vld_d = 1'b0;
          if (first_of_image_i) begin
            count_d = '0;
            last_d  = '0;
          end
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        // Issue the next read while entries remain
        if (scan_q < count_q) begin
          rd_en_o   = 1'b1;
          scan_d    = scan_q + CW'(1);
          cmp_vld_d = 1'b1;
          cmp_idx_d = scan_q[AW-1:0];
        end else begin
          cmp_vld_d = 1'b0;
        end
        // Compare the entry read last cycle; first match wins
        if (cmp_vld_q && (rd_data_i == color_q)) begin
          hit_d     = 1'b1;
          hit_idx_d = cmp_idx_q;
          state_d   = S_RESOLVE;
        end else if (!cmp_vld_q && (scan_q == count_q)) begin
          hit_d   = 1'b0;
          state_d = S_RESOLVE;
        end
      end

      S_RESOLVE: begin
        res_valid_o = 1'b1;
        if (hit_q) begin
          res_o.pal_index     = 8'(hit_idx_q) + INDEX_OFFSET;
          res_o.colors_in_use = 8'(count_q);
          if (res_take_i) begin
            last_d = res_o.pal_index;
          end
        end else if (room) begin
          res_o.pal_index     = 8'(count_q) + INDEX_OFFSET;
          res_o.new_color     = 1'b1;
          res_o.colors_in_use = 8'(count_q + CW'(1));
          if (res_take_i) begin
            wr_en_o = 1'b1;
            last_d  = res_o.pal_index;
            count_d = count_q + CW'(1);
          end
        end else begin
          res_o.pal_index     = last_q;
          res_o.colors_in_use = 8'(count_q);
          res_o.color_dropped = 1'b1;
        end
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      last_q    <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      scan_q    <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      last_q    <= last_d;
      cmp_vld_q <= cmp_vld_d;
      hit_q     <= hit_d;
      scan_q    <= scan_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    color_q   <= color_d;
    cmp_idx_q <= cmp_idx_d;
    hit_idx_q <= hit_idx_d;
  end

endmodule : ppb_search

`default_nettype wire

FILE: rtl/pixel_palette_builder_core.sv
// Pixel palette builder, top level: search engine, palette memory and
// output register. Depends on ppb_pkg, ppb_palette_ram and ppb_search.
//
// Usage: pixels enter on the input channel (in_valid_i / in_stall_o) with
// red, green, blue and a first-of-image flag that empties the palette before
// the pixel is handled. One result item per pixel leaves on the output
// channel (out_valid_o / out_stall_i): palette index (slot plus 32), new-color
// and dropped flags, and the number of palette entries in use.
// One pixel is handled at a time. A miss sweeps every filled palette entry,
// one read per cycle through the registered read port, and then closes the
// sweep; a hit ends it at the first matching slot, and an empty palette is
// resolved with no read at all. The next pixel is accepted once the result
// has been taken.
// The result sits in an output register; the next pixel is taken while a
// result still waits there. When the receiver stalls, the held result stays
// and a second finished result waits in the engine until the slot frees.
// Reset clears the palette count, the last index and all valid flags; the
// palette memory itself needs no clearing pass.
`default_nettype none

module pixel_palette_builder_core
  import ppb_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = 224
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // pixel channel
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] red_i,
  input  wire logic [7:0] green_i,
  input  wire logic [7:0] blue_i,
  input  wire logic       first_of_image_i,
  // result channel
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      pal_index_o,
  output logic            new_color_o,
  output logic [7:0]      colors_in_use_o,
  output logic            color_dropped_o
);

  localparam int unsigned AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(PALETTE_DEPTH + 1);

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  color_t        rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  color_t        wr_data;
  logic          res_valid;
  logic          res_take;
  ppb_result_t   res;

  logic          out_vld_q;
  ppb_result_t   out_q;

  ppb_palette_ram #(
    .DEPTH (PALETTE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  ppb_search #(
    .DEPTH (PALETTE_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_search (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .color_i          ({red_i, green_i, blue_i}),
    .first_of_image_i (first_of_image_i),
    .rd_en_o          (rd_en),
    .rd_addr_o        (rd_addr),
    .rd_data_i        (rd_data),
    .wr_en_o          (wr_en),
    .wr_addr_o        (wr_addr),
    .wr_data_o        (wr_data),
    .res_valid_o      (res_valid),
    .res_take_i       (res_take),
    .res_o            (res)
  );

  // Slot is free when empty or being drained this cycle
  assign res_take = !out_vld_q || !out_stall_i;

  // Output valid: load on a new result, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_take) begin
      out_vld_q <= res_valid;
    end
  end

  // Output payload: hold while stalled
  always_ff @(posedge clk_i) begin
    if (res_take && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign pal_index_o     = out_q.pal_index;
  assign new_color_o     = out_q.new_color;
  assign colors_in_use_o = out_q.colors_in_use;
  assign color_dropped_o = out_q.color_dropped;

endmodule : pixel_palette_builder_core

`default_nettype wire
